FILE: src/fmrc_pkg.sv
`timescale 1ns / 1ps

package fmrc_pkg;

  localparam int S_TDATA_W = 208;
  localparam int M_TDATA_W = 8;
  localparam int CFG_W     = 7;
  localparam int SLOT_FW   = 6;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // -1.0 in Q20.4
  localparam logic signed [23:0] HEIGHT_UNKNOWN = -24'sd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        [15:0] kind;
    logic signed [15:0] curve_lim;
    logic signed [23:0] len_min;
    logic signed [23:0] len_max;
    logic signed [23:0] hgt_min;
    logic signed [23:0] hgt_max;
    logic signed [23:0] seg_min;
    logic signed [23:0] seg_max;
    logic        [9:0]  cnt_min;
    logic        [9:0]  cnt_max;
  } rule_t;

  typedef struct packed {
    logic        [15:0] kind;
    logic signed [15:0] curve;
    logic signed [23:0] len;
    logic signed [23:0] hgt_one;
    logic signed [23:0] hgt_two;
    logic signed [23:0] seg_small;
    logic signed [23:0] seg_big;
    logic        [9:0]  seg_cnt;
  } query_t;

endpackage

FILE: src/fmrc_rule_mem.sv
`timescale 1ns / 1ps

module fmrc_rule_mem
  import fmrc_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rule_t         wr_rule,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rule_t         rd_rule
);

  rule_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rule <= mem[rd_addr];
    end
  end

endmodule

FILE: src/fmrc_match_unit.sv
`timescale 1ns / 1ps

module fmrc_match_unit
  import fmrc_pkg::*;
(
  input  rule_t  rule,
  input  query_t query,
  output logic   hit
);

  logic kind_ok;
  logic curve_ok;
  logic len_ok;
  logic hgt_one_ok;
  logic hgt_two_ok;
  logic seg_ok;
  logic cnt_ok;
  logic hgt_wild;

  always_comb begin
    hgt_wild   = (rule.hgt_min == rule.hgt_max);
    kind_ok    = (rule.kind == query.kind);
    curve_ok   = (rule.curve_lim <= query.curve);
    len_ok     = (rule.len_min == rule.len_max) ||
                 ((rule.len_min <= query.len) && (query.len <= rule.len_max));
    hgt_one_ok = hgt_wild || (query.hgt_one == HEIGHT_UNKNOWN) ||
                 ((rule.hgt_min <= query.hgt_one) && (query.hgt_one <= rule.hgt_max));
    hgt_two_ok = hgt_wild || (query.hgt_two == HEIGHT_UNKNOWN) ||
                 ((rule.hgt_min <= query.hgt_two) && (query.hgt_two <= rule.hgt_max));
    seg_ok     = (rule.seg_min == rule.seg_max) ||
                 ((rule.seg_min <= query.seg_small) && (query.seg_big <= rule.seg_max));
    cnt_ok     = (rule.cnt_min == rule.cnt_max) ||
                 ((rule.cnt_min <= query.seg_cnt) && (query.seg_cnt <= rule.cnt_max));
    hit = kind_ok && curve_ok && len_ok && hgt_one_ok && hgt_two_ok && seg_ok && cnt_ok;
  end

endmodule

FILE: src/first_match_range_rule_classifier_top.sv
// Load beat: written to its slot if the slot is below RULE_SLOTS; the next beat may
// follow at once. Query beat: the scan checks the slots below L = min(active_rules,
// RULE_SLOTS); a hit at slot k ends the scan early. The scan reads one
// rule per cycle from the single read port of the rule memory; a new beat is taken
// the cycle after the result is registered, which waits until the output is free.
// Reset clears control and active_rules only; rule slots hold no value until loaded.
`timescale 1ns / 1ps

module first_match_range_rule_classifier_top
  import fmrc_pkg::*;
#(
  parameter int RULE_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // rule_slot, road_kind, curve_value, length_a, length_b, height_a, height_b,
  // seg_length_a, seg_length_b, seg_count_a, seg_count_b, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // func
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // matched, match_slot, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  state_t              state;
  state_t              state_next;
  logic [CFG_W-1:0]    active_rules;
  query_t              query;
  query_t              query_in;
  rule_t               rule_in;
  rule_t               rd_rule;
  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    cnt;
  logic                chk_valid;
  logic [SLOT_W-1:0]   chk_slot;
  logic                res_matched;
  logic [SLOT_FW-1:0]  res_slot;
  logic                out_matched;
  logic [SLOT_FW-1:0]  out_slot;
  logic                hit;
  logic                in_accept;
  logic                out_free;
  logic                scan_hit;
  logic                scan_end;
  logic                rd_en;
  logic                wr_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic [SLOT_W-1:0]   wr_addr;
  logic [SLOT_FW-1:0]  in_slot;

  assign in_slot = s_axis_tdata[5:0];

  assign rule_in.kind      = s_axis_tdata[21:6];
  assign rule_in.curve_lim = s_axis_tdata[37:22];
  assign rule_in.len_min   = s_axis_tdata[61:38];
  assign rule_in.len_max   = s_axis_tdata[85:62];
  assign rule_in.hgt_min   = s_axis_tdata[109:86];
  assign rule_in.hgt_max   = s_axis_tdata[133:110];
  assign rule_in.seg_min   = s_axis_tdata[157:134];
  assign rule_in.seg_max   = s_axis_tdata[181:158];
  assign rule_in.cnt_min   = s_axis_tdata[191:182];
  assign rule_in.cnt_max   = s_axis_tdata[201:192];

  assign query_in.kind      = s_axis_tdata[21:6];
  assign query_in.curve     = s_axis_tdata[37:22];
  assign query_in.len       = s_axis_tdata[61:38];
  assign query_in.hgt_one   = s_axis_tdata[109:86];
  assign query_in.hgt_two   = s_axis_tdata[133:110];
  assign query_in.seg_small = s_axis_tdata[157:134];
  assign query_in.seg_big   = s_axis_tdata[181:158];
  assign query_in.seg_cnt   = s_axis_tdata[191:182];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {1'b0, out_slot, out_matched};

  assign scan_hit = chk_valid && hit;
  assign scan_end = (cnt == lim);
  assign rd_en    = (state == ST_SCAN) && !scan_end;
  assign rd_addr  = cnt[SLOT_W-1:0];
  assign wr_addr  = SLOT_W'(in_slot);
  assign wr_en    = in_accept && (s_axis_tuser == FUNC_LOAD) &&
                    (32'(in_slot) < 32'(RULE_SLOTS));

  fmrc_rule_mem #(
    .DEPTH (RULE_SLOTS),
    .AW    (SLOT_W)
  ) u_rule_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_rule (rule_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_rule (rd_rule)
  );

  fmrc_match_unit u_match (
    .rule  (rd_rule),
    .query (query),
    .hit   (hit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (s_axis_tuser == FUNC_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active_rules  <= '0;
      chk_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= rd_en;
      if (cfg_wr_en) begin
        active_rules <= cfg_wr_data;
      end
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (s_axis_tuser == FUNC_QUERY)) begin
      query <= query_in;
      cnt   <= '0;
      if (CMP_W'(active_rules) > CMP_W'(RULE_SLOTS)) begin
        lim <= CNT_W'(RULE_SLOTS);
      end else begin
        lim <= CNT_W'(active_rules);
      end
    end else if (rd_en) begin
      cnt <= cnt + 1'b1;
    end
    chk_slot <= rd_addr;
    if (state == ST_SCAN) begin
      if (scan_hit) begin
        res_matched <= 1'b1;
        res_slot    <= SLOT_FW'(chk_slot);
      end else if (scan_end) begin
        res_matched <= 1'b0;
        res_slot    <= '0;
      end
    end
    if (state == ST_DONE && out_free) begin
      out_matched <= res_matched;
      out_slot    <= res_slot;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt <= lim))
    else $error("scan counter passed the active limit");

  a_chk_in_limit: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (CNT_W'(chk_slot) < lim))
    else $error("checked slot outside active rules");

  a_hit_result: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && scan_hit) |=>
      (res_matched && (res_slot == SLOT_FW'($past(chk_slot)))))
    else $error("hit not captured as first match");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_matched) |-> (out_slot == '0))
    else $error("miss result carries a nonzero slot");

endmodule
